/* sv/bscl_pkg.sv */
// ----------------------------------------------------------------------------
// bscl_pkg
// Shared types and constants for the button short-press / chord classifier.
// ----------------------------------------------------------------------------
package bscl_pkg;

  // Default width of the wrapping millisecond time
  localparam int unsigned TIME_BITS_DEFAULT = 32;

  // Widths of the port fields
  localparam int unsigned NOW_BITS       = 32;
  localparam int unsigned THR_BITS       = 16;
  localparam int unsigned BTN_COUNT      = 4;
  localparam int unsigned CFG_INDEX_BITS = 8;
  localparam int unsigned S_TDATA_BITS   = 40;
  localparam int unsigned M_TDATA_BITS   = 8;

  // Button bit positions in the level vectors
  localparam int unsigned BTN_UP    = 0;
  localparam int unsigned BTN_DOWN  = 1;
  localparam int unsigned BTN_LEFT  = 2;
  localparam int unsigned BTN_RIGHT = 3;

  // Register reset values
  localparam logic [THR_BITS-1:0] MIN_PRESS_RESET  = 16'd50;
  localparam logic [THR_BITS-1:0] LONG_PRESS_RESET = 16'd1000;

  // Configuration register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_MIN_PRESS  = 8'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_LONG_PRESS = 8'd1;

  // Threshold settings seen by the classifier core
  typedef struct packed {
    logic [THR_BITS-1:0] min_press_ms;
    logic [THR_BITS-1:0] long_press_ms;
  } cfg_t;

  // Event flags of one result word
  typedef struct packed {
    logic combo_long;
    logic right;
    logic left;
    logic down;
    logic up;
  } evt_t;

endpackage

/* sv/button_short_and_combo_long_press.sv */
// ----------------------------------------------------------------------------
// button_short_and_combo_long_press
// Four-button poll classifier: short presses and a left+right long chord.
// ----------------------------------------------------------------------------
// Each input word is one poll: four button levels and a wrapping millisecond
// time. Each poll yields exactly one result word of event flags. A button's
// event fires when it is released after at least min_press_ms of hold; holding
// left and right together cancels and blocks individual presses, and the
// chord event fires once after long_press_ms. Rate: one word per clock unless
// m_tready stalls; a poll passes the input register, then the classification
// logic into the result register. The user must write registers through the
// cfg channel only while no poll is in flight; the block does not enforce it.
module button_short_and_combo_long_press
  import bscl_pkg::*;
#(
  parameter int unsigned TIME_BITS = TIME_BITS_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  // Poll words
  input  logic                      s_tvalid,
  output logic                      s_tready,
  // [0] level_up, [1] level_down, [2] level_left, [3] level_right,
  // [35:4] now_ms, [39:36] zero
  input  logic [S_TDATA_BITS-1:0]   s_tdata,
  // Result words
  output logic                      m_tvalid,
  input  logic                      m_tready,
  // [0] event_up, [1] event_down, [2] event_left, [3] event_right,
  // [4] event_combo_long, [7:5] zero
  output logic [M_TDATA_BITS-1:0]   m_tdata,
  // Register writes
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [THR_BITS-1:0]       cfg_data
);

  logic                 in_valid;
  logic [BTN_COUNT-1:0] in_levels;
  logic [NOW_BITS-1:0]  in_now;
  logic                 advance, step;
  cfg_t                 cfg;
  evt_t                 events, out_evt;

  // Pipeline moves when the result register is free or being drained
  assign advance  = !m_tvalid || m_tready;
  assign s_tready = !in_valid || advance;
  assign step     = in_valid && advance;

  // Configuration registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_press_ms  <= MIN_PRESS_RESET;
      cfg.long_press_ms <= LONG_PRESS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MIN_PRESS:  cfg.min_press_ms  <= cfg_data;
        REG_LONG_PRESS: cfg.long_press_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_levels <= s_tdata[BTN_COUNT-1:0];
      in_now    <= s_tdata[BTN_COUNT +: NOW_BITS];
    end
  end

  // Classifier
  bscl_core #(
    .TIME_BITS (TIME_BITS)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .levels (in_levels),
    .now_ms (in_now),
    .cfg    (cfg),
    .events (events)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_evt <= events;
    end
  end

  assign m_tdata = M_TDATA_BITS'({out_evt.combo_long, out_evt.right, out_evt.left,
                                  out_evt.down, out_evt.up});

endmodule

/* sv/bscl_core.sv */
// ----------------------------------------------------------------------------
// bscl_core
// Press/chord state and the single-pass classification of one poll word.
// ----------------------------------------------------------------------------
module bscl_core
  import bscl_pkg::*;
#(
  parameter int unsigned TIME_BITS = TIME_BITS_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  logic [BTN_COUNT-1:0] levels,
  input  logic [NOW_BITS-1:0]  now_ms,
  input  cfg_t                 cfg,
  output evt_t                 events
);

  localparam logic [BTN_COUNT-1:0] PAIR = BTN_COUNT'((1 << BTN_LEFT) | (1 << BTN_RIGHT));

  // State
  logic [BTN_COUNT-1:0] prev_levels, prev_levels_next;
  logic [BTN_COUNT-1:0] press_active, press_active_next;
  logic [TIME_BITS-1:0] press_start [BTN_COUNT];
  logic [TIME_BITS-1:0] press_start_next [BTN_COUNT];
  logic                 combo_active, combo_active_next;
  logic [TIME_BITS-1:0] combo_start, combo_start_next;
  logic                 combo_fired, combo_fired_next;

  // Intermediate values of one poll
  logic [TIME_BITS-1:0] now_t;
  logic [TIME_BITS-1:0] min_t, long_t;
  logic [TIME_BITS-1:0] combo_el;
  logic [TIME_BITS-1:0] btn_el [BTN_COUNT];
  logic                 pair_down, chord_start, chord_end, chord_fire;
  logic                 ca1, cf1;
  logic [BTN_COUNT-1:0] pa1, pa2, pa3;
  logic [BTN_COUNT-1:0] rel_evt;

  assign now_t  = TIME_BITS'(now_ms);
  assign min_t  = TIME_BITS'(cfg.min_press_ms);
  assign long_t = TIME_BITS'(cfg.long_press_ms);

  // Chord start and fire
  always_comb begin
    pair_down   = (levels & PAIR) == PAIR;
    chord_start = pair_down && !combo_active;
    ca1         = combo_active || chord_start;
    cf1         = chord_start ? 1'b0 : combo_fired;
    combo_start_next = chord_start ? now_t : combo_start;
    pa1         = chord_start ? (press_active & ~PAIR) : press_active;
    combo_el    = now_t - combo_start_next;
    chord_fire  = ca1 && !cf1 && (combo_el >= long_t);
    chord_end   = ca1 && !pair_down;
  end

  // Press starts, chord end, releases
  always_comb begin
    pa2 = pa1;
    for (int i = 0; i < BTN_COUNT; i++) begin
      press_start_next[i] = press_start[i];
      if (!ca1 && levels[i] && !prev_levels[i] && !pa1[i]) begin
        pa2[i]              = 1'b1;
        press_start_next[i] = now_t;
      end
    end
    pa3 = chord_end ? (pa2 & ~PAIR) : pa2;
    for (int i = 0; i < BTN_COUNT; i++) begin
      btn_el[i]  = now_t - press_start_next[i];
      rel_evt[i] = pa3[i] && !levels[i] && (btn_el[i] >= min_t);
    end
    press_active_next = pa3 & levels;
    combo_active_next = ca1 && pair_down;
    combo_fired_next  = chord_end ? 1'b0 : (cf1 || chord_fire);
    prev_levels_next  = levels;
  end

  assign events.up         = rel_evt[BTN_UP];
  assign events.down       = rel_evt[BTN_DOWN];
  assign events.left       = rel_evt[BTN_LEFT];
  assign events.right      = rel_evt[BTN_RIGHT];
  assign events.combo_long = chord_fire;

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_levels  <= '0;
      press_active <= '0;
      combo_active <= 1'b0;
      combo_fired  <= 1'b0;
      combo_start  <= '0;
      for (int i = 0; i < BTN_COUNT; i++) begin
        press_start[i] <= '0;
      end
    end else if (step) begin
      prev_levels  <= prev_levels_next;
      press_active <= press_active_next;
      combo_active <= combo_active_next;
      combo_fired  <= combo_fired_next;
      combo_start  <= combo_start_next;
      for (int i = 0; i < BTN_COUNT; i++) begin
        press_start[i] <= press_start_next[i];
      end
    end
  end

  // Checks
  a_fired_needs_chord: assert property (@(posedge clk) disable iff (rst)
    !combo_active |-> !combo_fired)
    else $error("chord marked fired while no chord is active");

  a_chord_levels: assert property (@(posedge clk) disable iff (rst)
    combo_active |-> (prev_levels[BTN_LEFT] && prev_levels[BTN_RIGHT]))
    else $error("chord active without left and right down");

  a_chord_cancels: assert property (@(posedge clk) disable iff (rst)
    combo_active |-> (!press_active[BTN_LEFT] && !press_active[BTN_RIGHT]))
    else $error("left or right press pending during a chord");

  a_fire_once: assert property (@(posedge clk) disable iff (rst)
    (step && events.combo_long && pair_down) |=> combo_fired)
    else $error("chord event not recorded as fired");

  a_release_level: assert property (@(posedge clk) disable iff (rst)
    (step && events.left) |-> !levels[BTN_LEFT])
    else $error("left event while left still down");

endmodule

/* test/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the button short-press / left+right chord classifier.
// ----------------------------------------------------------------------------
// Sends poll words (button levels plus a wrapping ms time) and checks every
// result word against a local classifier that models the press and chord
// state. Sequences are mostly well-formed presses and chords with timing near
// the thresholds. The rest is broken chords and noise. The thresholds are
// changed between phases while the block is idle. Both sides stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import bscl_pkg::*;

  // Button masks in the level vector
  localparam logic [3:0] UP_M    = 4'b0001 << BTN_UP;
  localparam logic [3:0] DOWN_M  = 4'b0001 << BTN_DOWN;
  localparam logic [3:0] LEFT_M  = 4'b0001 << BTN_LEFT;
  localparam logic [3:0] RIGHT_M = 4'b0001 << BTN_RIGHT;
  localparam logic [3:0] PAIR_M  = LEFT_M | RIGHT_M;

  // Index that maps to no register; writes to it must be dropped
  localparam logic [CFG_INDEX_BITS-1:0] REG_UNMAPPED = 8'hFF;

  localparam int PHASE_POLLS = 150;

  // Expected-event tracker: keeps its own press/chord state and thresholds
  class press_scoreboard;
    logic [THR_BITS-1:0] min_ms;
    logic [THR_BITS-1:0] long_ms;
    logic [3:0]          prev_lv;
    logic [3:0]          held;
    logic [31:0]         t0 [4];
    bit                  chord_on;
    bit                  chord_done;
    logic [31:0]         chord_t;
    evt_t                pending_events [$];
    int                  failures;
    int                  results_seen;

    function new();
      min_ms       = MIN_PRESS_RESET;
      long_ms      = LONG_PRESS_RESET;
      prev_lv      = '0;
      held         = '0;
      foreach (t0[i]) t0[i] = '0;
      chord_on     = 0;
      chord_done   = 0;
      chord_t      = '0;
      failures     = 0;
      results_seen = 0;
    endfunction

    function void write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [THR_BITS-1:0] val);
      if (idx == REG_MIN_PRESS) min_ms = val;
      else if (idx == REG_LONG_PRESS) long_ms = val;
    endfunction

    function int pending();
      return pending_events.size();
    endfunction

    // Classify one accepted poll and queue the events it should raise
    function void note_poll(logic [3:0] lv, logic [31:0] now);
      evt_t        ev;
      logic [3:0]  fired;
      logic [31:0] elapsed;
      ev    = '0;
      fired = '0;
      // chord start cancels the pending left/right presses
      if (lv[BTN_LEFT] && lv[BTN_RIGHT] && !chord_on) begin
        chord_on          = 1;
        chord_t           = now;
        chord_done        = 0;
        held[BTN_LEFT]    = 1'b0;
        held[BTN_RIGHT]   = 1'b0;
      end
      // chord fires once
      elapsed = now - chord_t;
      if (chord_on && !chord_done && elapsed >= {16'd0, long_ms}) begin
        chord_done    = 1;
        ev.combo_long = 1'b1;
      end
      // new presses only outside a chord
      if (!chord_on) begin
        for (int i = 0; i < BTN_COUNT; i++) begin
          if (lv[i] && !prev_lv[i] && !held[i]) begin
            held[i] = 1'b1;
            t0[i]   = now;
          end
        end
      end
      // chord end
      if (chord_on && !(lv[BTN_LEFT] && lv[BTN_RIGHT])) begin
        held[BTN_LEFT]  = 1'b0;
        held[BTN_RIGHT] = 1'b0;
        chord_on        = 0;
        chord_done      = 0;
      end
      // releases
      for (int i = 0; i < BTN_COUNT; i++) begin
        if (held[i] && !lv[i]) begin
          elapsed = now - t0[i];
          if (elapsed >= {16'd0, min_ms}) fired[i] = 1'b1;
          held[i] = 1'b0;
        end
      end
      prev_lv  = lv;
      ev.up    = fired[BTN_UP];
      ev.down  = fired[BTN_DOWN];
      ev.left  = fired[BTN_LEFT];
      ev.right = fired[BTN_RIGHT];
      pending_events.push_back(ev);
    endfunction

    function void flag(string what, int want, int got);
      failures++;
      if (failures <= 10)
        $display("[%0t] result %0d %s: expected %0d, got %0d",
                 $time, results_seen, what, want, got);
    endfunction

    // Compare one result word with the oldest expectation
    function void check_events(logic [M_TDATA_BITS-1:0] word);
      evt_t want;
      evt_t got;
      got = evt_t'(word[4:0]);
      results_seen++;
      if (pending_events.size() == 0) begin
        flag("word with no poll pending", 0, word);
        return;
      end
      want = pending_events.pop_front();
      if (got.up !== want.up) flag("event_up", want.up, got.up);
      if (got.down !== want.down) flag("event_down", want.down, got.down);
      if (got.left !== want.left) flag("event_left", want.left, got.left);
      if (got.right !== want.right) flag("event_right", want.right, got.right);
      if (got.combo_long !== want.combo_long)
        flag("event_combo_long", want.combo_long, got.combo_long);
      if (word[M_TDATA_BITS-1:5] !== '0) flag("pad bits", 0, word[M_TDATA_BITS-1:5]);
    endfunction
  endclass

  logic                      clk;
  logic                      rst;
  logic                      s_tvalid;
  logic                      s_tready;
  logic [S_TDATA_BITS-1:0]   s_tdata;
  logic                      m_tvalid;
  logic                      m_tready;
  logic [M_TDATA_BITS-1:0]   m_tdata;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [THR_BITS-1:0]       cfg_data;

  press_scoreboard sb;
  bit              no_idle;
  logic [31:0]     t_now;
  int              polls_sent;

  button_short_and_combo_long_press u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit
  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

  // Mostly no gap, some short, a few long
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // Hold time around a threshold: just under, at, just over, or spread out
  function automatic logic [31:0] near_value(logic [THR_BITS-1:0] th);
    logic [31:0] th32;
    th32 = {16'd0, th};
    case ($urandom_range(0, 5))
      0:       return th32 - 1;
      1:       return th32;
      2:       return th32 + 1;
      3:       return $urandom_range(0, 2 * th32 + 2);
      4:       return th32 + $urandom_range(2, 500);
      default: return $urandom_range(0, th32);
    endcase
  endfunction

  // Monitor both handshakes
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.note_poll(s_tdata[3:0], s_tdata[35:4]);
      if (m_tvalid && m_tready) sb.check_events(m_tdata);
    end
  end

  // Result side back-pressure
  initial begin
    m_tready = 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      int n;
      n = pick_gap();
      if (n > 0) begin
        m_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      m_tready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  // Send one poll word; returns at the edge that accepts it
  task automatic poll(input logic [3:0] lv, input logic [31:0] t);
    int gap;
    gap   = pick_gap();
    t_now = t;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0, t, lv};
    do @(posedge clk); while (!s_tready);
    polls_sent++;
  endtask

  // Stop sending and let every outstanding result drain
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [THR_BITS-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, val);
  endtask

  task automatic set_thresholds(input logic [THR_BITS-1:0] min_v,
                                input logic [THR_BITS-1:0] long_v,
                                input bit add_unmapped);
    wait_idle();
    if ($urandom_range(0, 1)) begin
      write_reg(REG_MIN_PRESS, min_v);
      write_reg(REG_LONG_PRESS, long_v);
    end else begin
      write_reg(REG_LONG_PRESS, long_v);
      write_reg(REG_MIN_PRESS, min_v);
    end
    if (add_unmapped) write_reg(REG_UNMAPPED, 16'($urandom));
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Single or multi-button press, hold, release near the minimum hold
  task automatic press_seq();
    logic [3:0]  m;
    logic [31:0] ts;
    logic [31:0] tr;
    int          k;
    m = 4'($urandom_range(1, 15));
    if ((m & PAIR_M) == PAIR_M && $urandom_range(0, 3) != 0)
      m &= ~($urandom_range(0, 1) ? LEFT_M : RIGHT_M);
    ts = t_now + $urandom_range(0, 40);
    poll(m, ts);
    k = $urandom_range(0, 3);
    repeat (k) poll(m, ts + $urandom_range(0, sb.min_ms));
    tr = ts + near_value(sb.min_ms);
    if ($urandom_range(0, 2) == 0) begin
      m = m & 4'($urandom);
      poll(m, tr);
      tr = tr + $urandom_range(0, 60);
    end
    poll(4'b0, tr);
  endtask

  // Left+right chord held around the long-press time
  task automatic chord_seq();
    logic [3:0]  first;
    logic [3:0]  extra;
    logic [31:0] tc;
    logic [31:0] tf;
    int          k;
    first = $urandom_range(0, 1) ? LEFT_M : RIGHT_M;
    extra = $urandom_range(0, 1) ? 4'($urandom_range(0, 3)) : 4'b0;
    poll(first | extra, t_now + $urandom_range(0, 40));
    tc = t_now + $urandom_range(0, 60);
    poll(PAIR_M | extra, tc);
    k = $urandom_range(0, 3);
    // up/down presses inside the chord are blocked
    repeat (k) poll(PAIR_M | 4'($urandom_range(0, 3)), tc + $urandom_range(0, sb.long_ms));
    tf = tc + near_value(sb.long_ms);
    poll(PAIR_M | extra, tf);
    if ($urandom_range(0, 1)) poll(PAIR_M | extra, tf + $urandom_range(0, 3000));
    // one side let go first, the other still down
    if ($urandom_range(0, 1)) poll(($urandom_range(0, 1) ? LEFT_M : RIGHT_M) | extra,
                                   t_now + $urandom_range(0, 30));
    poll(4'b0, t_now + near_value(sb.min_ms));
  endtask

  // Chord that bounces, or a press that bounces near the minimum hold
  task automatic broken_seq();
    logic [3:0]  m;
    logic [31:0] ts;
    ts = t_now + $urandom_range(0, 40);
    if ($urandom_range(0, 1)) begin
      poll(PAIR_M, ts);
      poll($urandom_range(0, 1) ? LEFT_M : RIGHT_M, ts + $urandom_range(0, 5));
      poll(PAIR_M, ts + $urandom_range(5, 10));
      poll(PAIR_M | 4'($urandom_range(0, 3)), ts + near_value(sb.long_ms));
    end else begin
      m = 4'b0001 << $urandom_range(0, 3);
      poll(m, ts);
      poll(4'b0, ts + $urandom_range(0, 5));
      poll(m, ts + $urandom_range(5, 10));
      poll(m, ts + near_value(sb.min_ms));
    end
    poll(4'b0, t_now + $urandom_range(0, 200));
  endtask

  // Random levels; time may jump anywhere, backwards included
  task automatic noise_seq();
    repeat ($urandom_range(1, 4))
      poll(4'($urandom_range(0, 15)),
           $urandom_range(0, 3) == 0 ? $urandom : t_now + $urandom_range(0, 100));
  endtask

  initial begin
    rst        = 1'b1;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    no_idle    = 0;
    t_now      = '0;
    polls_sent = 0;
    sb         = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset thresholds (50 ms press, 1000 ms chord)
    poll(4'b0, 32'd0);
    poll(UP_M, 32'd100);                 // release exactly at minimum hold
    poll(4'b0, 32'd150);
    poll(DOWN_M, 32'd200);               // one short of minimum hold
    poll(4'b0, 32'd249);
    poll(LEFT_M, 32'd300);               // left press gets cancelled by chord
    poll(PAIR_M, 32'd310);
    poll(PAIR_M | UP_M, 32'd1309);       // up blocked, chord one short
    poll(PAIR_M | UP_M, 32'd1310);       // chord fires
    poll(PAIR_M, 32'd2000);              // no second chord event
    poll(RIGHT_M, 32'd2100);             // chord ends, no left/right event
    poll(4'b0, 32'd2200);
    poll(RIGHT_M, 32'hFFFF_FFF0);        // hold across time wrap
    poll(4'b0, 32'h0000_0030);
    poll(DOWN_M, 32'd5000);              // time going backwards
    poll(4'b0, 32'd4990);
    poll(4'hF, 32'hFFFF_FFFF);           // all buttons, top of time range
    poll(4'b0, 32'd0);

    // Directed: zero thresholds, plus a write to an unmapped index
    set_thresholds(16'd0, 16'd0, 1'b1);
    poll(UP_M | DOWN_M, 32'd7000);       // zero hold still fires
    poll(4'b0, 32'd7000);
    poll(PAIR_M, 32'd7001);              // chord fires on its first poll
    poll(4'b0, 32'd7002);

    // Random phases over several threshold settings
    for (int phase = 0; phase < 6; phase++) begin
      int start_cnt;
      case (phase)
        0:       set_thresholds(16'd0, 16'd0, 1'b0);
        1:       set_thresholds(16'hFFFF, 16'hFFFF, 1'b1);
        2:       set_thresholds(MIN_PRESS_RESET, LONG_PRESS_RESET, 1'b0);
        3:       set_thresholds(16'($urandom_range(0, 100)), 16'($urandom_range(0, 300)), 1'b1);
        4:       set_thresholds(16'd1, 16'd2, 1'b0);
        default: set_thresholds(16'($urandom), 16'($urandom), 1'b1);
      endcase
      no_idle   = (phase == 3);
      start_cnt = polls_sent;
      while (polls_sent - start_cnt < PHASE_POLLS) begin
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) press_seq();
        else if (r < 70) chord_seq();
        else if (r < 85) broken_seq();
        else noise_seq();
      end
    end

    no_idle = 0;
    wait_idle();
    repeat (6) @(posedge clk);
    if (sb.failures == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
